// ----- rtl/bsc_pkg.sv -----
package bsc_pkg;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [18:0] raw_press;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic signed [31:0] pressure;
    logic               fault;
  } out_req_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OSS     = 3'd5;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  // Step counter of the shared iterative divider (32 steps)
  localparam int unsigned TDIV_CNT_W = 6;

  typedef struct packed {
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
    logic [1:0]  oss;
  } coef_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
    asr = 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] full;
    full = 64'(a) * 64'(b);
    mul32 = full[31:0];
  endfunction

endpackage

// ----- rtl/bsc_front.sv -----
// Front: accepts requests and queues them for the back end.
module bsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bsc_pkg::in_req_t  in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output bsc_pkg::in_req_t  q_data
);

  bsc_pkg::in_req_t             mem_r [bsc_pkg::QUEUE_DEPTH];
  logic [bsc_pkg::QPTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [bsc_pkg::QPTR_W:0]     cnt_r, cnt_nxt;
  logic                         push;

  assign in_stall = (cnt_r == (bsc_pkg::QPTR_W+1)'(bsc_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push  ? wp_r + 1'b1 : wp_r;
    rp_nxt  = q_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (bsc_pkg::QPTR_W+1)'(push) - (bsc_pkg::QPTR_W+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= in_data;
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (bsc_pkg::QPTR_W+1)'(bsc_pkg::QUEUE_DEPTH)) else $error("queue overflow");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");

endmodule

// ----- rtl/bsc_back.sv -----
// Back: sequencer over temperature and pressure, with a restoring divider
// shared by the two divisions (one quotient bit per cycle).
module bsc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bsc_pkg::coef_t    coef,
  input  logic              q_valid,
  output logic              q_pop,
  input  bsc_pkg::in_req_t  q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bsc_pkg::out_req_t out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_T1   = 4'd1;
  localparam logic [3:0] S_TDIV = 4'd2;
  localparam logic [3:0] S_T2   = 4'd3;
  localparam logic [3:0] S_P1   = 4'd4;
  localparam logic [3:0] S_P2   = 4'd5;
  localparam logic [3:0] S_P3   = 4'd6;
  localparam logic [3:0] S_P4   = 4'd7;
  localparam logic [3:0] S_PDIV = 4'd8;
  localparam logic [3:0] S_P5   = 4'd9;
  localparam logic [3:0] S_P6   = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]  st_r, st_nxt;
  logic [15:0] ut_r;
  logic [18:0] up_r;
  logic [31:0] x1_r, b6_r, sq_r, b3_r, b4_r, b7_r, p_r, t_r, a_r, c_r;
  logic        neg_r;
  // divider
  logic [31:0] dq_r, drem_r, dden_r;
  logic [bsc_pkg::TDIV_CNT_W-1:0] dcnt_r;
  logic        ovalid_r;
  bsc_pkg::out_req_t res_r;
  bsc_pkg::out_req_t odata_r;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] x1_t, tden;
  logic [32:0] trial;
  logic        last_bit;

  assign ac1 = bsc_pkg::sx16(coef.ac1_ac2[31:16]);
  assign ac2 = bsc_pkg::sx16(coef.ac1_ac2[15:0]);
  assign ac3 = bsc_pkg::sx16(coef.ac3_ac4[31:16]);
  assign ac4 = {16'd0, coef.ac3_ac4[15:0]};
  assign ac5 = {16'd0, coef.ac5_ac6[31:16]};
  assign ac6 = {16'd0, coef.ac5_ac6[15:0]};
  assign b1  = bsc_pkg::sx16(coef.b1_b2[31:16]);
  assign b2  = bsc_pkg::sx16(coef.b1_b2[15:0]);
  assign mc  = bsc_pkg::sx16(coef.mc_md[31:16]);
  assign md  = bsc_pkg::sx16(coef.mc_md[15:0]);

  assign x1_t     = bsc_pkg::asr(bsc_pkg::mul32({16'd0, ut_r} - ac6, ac5), 15);
  assign tden     = x1_t + md;
  assign trial    = {drem_r, dq_r[31]} - {1'b0, dden_r};
  assign last_bit = (dcnt_r == (bsc_pkg::TDIV_CNT_W)'(31));
  assign q_pop    = (st_r == S_IDLE) && q_valid;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid) st_nxt = S_T1;
      S_T1:   st_nxt = (tden == '0) ? S_DONE : S_TDIV;
      S_TDIV: if (last_bit) st_nxt = S_T2;
      S_T2:   st_nxt = S_P1;
      S_P1:   st_nxt = S_P2;
      S_P2:   st_nxt = S_P3;
      S_P3:   st_nxt = S_P4;
      S_P4:   st_nxt = (b4_r == '0) ? S_DONE : S_PDIV;
      S_PDIV: if (last_bit) st_nxt = S_P5;
      S_P5:   st_nxt = S_P6;
      S_P6:   st_nxt = S_DONE;
      S_DONE: if (!ovalid_r || !out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    logic [31:0] absd, absn, x2, x3, b3v, pv, q;
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      // result register refills only once the held result has gone
      if (st_r == S_DONE && (!ovalid_r || !out_stall)) begin
        ovalid_r <= 1'b1;
        odata_r  <= res_r;
      end else if (ovalid_r && !out_stall) begin
        ovalid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          ut_r <= q_data.raw_temp;
          up_r <= q_data.raw_press;
        end
        S_T1: begin
          x1_r <= x1_t;
        end
        S_TDIV: ;
        S_T2: ;
        S_P1: ;
        S_P2: ;
        S_P3: ;
        S_P4: ;
        S_PDIV: ;
        S_P5: ;
        S_P6: ;
        S_DONE: ;
        default: ;
      endcase
      // temperature division set-up (signed, truncating)
      if (st_r == S_T1) begin
        absd = tden[31] ? -tden : tden;
        absn = mc[31] ? -(mc << 11) : (mc << 11);
        neg_r  <= tden[31] ^ mc[31];
        dden_r <= absd;
        dq_r   <= absn;
        drem_r <= '0;
        dcnt_r <= '0;
        if (tden == '0) res_r <= '{temperature: '0, pressure: '0, fault: 1'b1};
      end
      if (st_r == S_TDIV || st_r == S_PDIV) begin
        if (!trial[32]) begin
          drem_r <= trial[31:0];
          dq_r   <= {dq_r[30:0], 1'b1};
        end else begin
          drem_r <= {drem_r[30:0], dq_r[31]};
          dq_r   <= {dq_r[30:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 1'b1;
      end
      if (st_r == S_T2) begin
        q = neg_r ? -dq_r : dq_r;
        t_r  <= bsc_pkg::asr(x1_r + q + 32'd8, 4);
        b6_r <= x1_r + q - 32'd4000;
      end
      if (st_r == S_P1) sq_r <= bsc_pkg::asr(bsc_pkg::mul32(b6_r, b6_r), 12);
      if (st_r == S_P2) begin
        x3 = bsc_pkg::asr(bsc_pkg::mul32(b2, sq_r), 11)
           + bsc_pkg::asr(bsc_pkg::mul32(ac2, b6_r), 11);
        b3v = bsc_pkg::asr(((bsc_pkg::mul32(ac1, 32'd4) + x3) << coef.oss) + 32'd2, 2);
        b3_r <= b3v;
        a_r <= bsc_pkg::asr(bsc_pkg::mul32(ac3, b6_r), 13);
        c_r <= bsc_pkg::asr(bsc_pkg::mul32(b1, sq_r), 16);
      end
      if (st_r == S_P3) begin
        x3 = bsc_pkg::asr(a_r + c_r + 32'd2, 2);
        b4_r <= bsc_pkg::mul32(ac4, x3 + 32'd32768) >> 15;
        b7_r <= bsc_pkg::mul32({13'd0, up_r} - b3_r, 32'd50000 >> coef.oss);
      end
      if (st_r == S_P4) begin
        dden_r <= b4_r;
        dq_r   <= b7_r[31] ? b7_r : (b7_r << 1);
        drem_r <= '0;
        dcnt_r <= '0;
        if (b4_r == '0) res_r <= '{temperature: '0, pressure: '0, fault: 1'b1};
      end
      if (st_r == S_P5) begin
        pv = b7_r[31] ? (dq_r << 1) : dq_r;
        p_r <= pv;
        a_r <= bsc_pkg::mul32(bsc_pkg::asr(pv, 8), bsc_pkg::asr(pv, 8));
        c_r <= bsc_pkg::asr(bsc_pkg::mul32(32'hFFFF_E343, pv), 16);
      end
      if (st_r == S_P6) begin
        x2 = bsc_pkg::asr(bsc_pkg::mul32(a_r, 32'd3038), 16);
        res_r <= '{temperature: t_r,
                   pressure: p_r + bsc_pkg::asr(x2 + c_r + 32'd3791, 4),
                   fault: 1'b0};
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TDIV || st_r == S_PDIV) |-> !q_pop) else $error("pop while busy");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.fault) |-> out_data.pressure == '0) else $error("fault data");

endmodule

// ----- rtl/baro_sensor_compensation.sv -----
// Sequence: S_T1, temperature division, S_T2, S_P1..S_P4, pressure division,
// S_P5, S_P6, S_DONE; a zero divisor ends it early in S_DONE with a fault.
// Throughput: one request at a time, set by one restoring divider doing two
// 32-step divisions; a 4-entry queue takes requests meanwhile.
// Reset: rst_n synchronous, active low; clears queue, sequencer, result valid
// and coefficient registers to 0.
module baro_sensor_compensation (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bsc_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bsc_pkg::out_req_t             out_data,
  input  logic                          cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                   cfg_wdata
);

  bsc_pkg::coef_t   coef_r;
  logic             q_valid, q_pop;
  bsc_pkg::in_req_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bsc_pkg::REG_AC1_AC2: coef_r.ac1_ac2 <= cfg_wdata;
        bsc_pkg::REG_AC3_AC4: coef_r.ac3_ac4 <= cfg_wdata;
        bsc_pkg::REG_AC5_AC6: coef_r.ac5_ac6 <= cfg_wdata;
        bsc_pkg::REG_B1_B2:   coef_r.b1_b2   <= cfg_wdata;
        bsc_pkg::REG_MC_MD:   coef_r.mc_md   <= cfg_wdata;
        bsc_pkg::REG_OSS:     coef_r.oss     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  bsc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_data
  );

  bsc_back u_back (
    .clk, .rst_n, .coef(coef_r), .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_data
  );

endmodule
